[hw/rtl/postfix_stack_evaluator_macros.svh]
// Assertion macros for the postfix stack evaluator checker.
`ifndef POSTFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PSE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pse_pkg.sv]
// Shared types and constants of the postfix stack evaluator.
`timescale 1ns / 1ps
`default_nettype none
package pse_pkg;
  localparam int StackDepth = 64;
  localparam int AddrW = $clog2(StackDepth);
  localparam int CountW = $clog2(StackDepth + 1);

  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;
  localparam logic [2:0] CMD_POW  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_ITER,
    S_WRITE,
    S_FINAL,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

[hw/rtl/postfix_stack_evaluator.sv]
// Top level: postfix expression evaluator on a memory-held operand stack.
// channel | dir | handshake      | payload
// in      | in  | in_valid/stall | command, operand_value, last
// out     | out | out_valid/stall| value, status
// Push and unused commands are taken in IDLE; add/sub/mul read both operands,
// compute and write back. Divide runs one radix-2 step per cycle; power
// alternates multiply and square over 31 exponent bits. Divide by zero and a
// negative exponent skip the iteration. A last token then reads out the result.
// Reset clears the count, status and control; the stack memory is not cleared.
// in_stall is high while a request is in work or a result is held on out_valid.
`timescale 1ns / 1ps
`default_nettype none
module postfix_stack_evaluator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  command,
  input  wire logic signed [31:0] operand_value,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] value,
  output logic [1:0]       status
);
  logic [31:0] mem [pse_pkg::StackDepth];
  logic [31:0] rd_data;
  logic [pse_pkg::AddrW-1:0] rd_addr;
  logic        wr_en;
  logic [pse_pkg::AddrW-1:0] wr_addr;
  logic [31:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  pse_pkg::state_t state, state_next;
  logic [pse_pkg::CountW-1:0] count, count_next;
  logic [1:0]  err, err_next;
  logic [2:0]  cmd, cmd_next;
  logic        lst, lst_next;
  logic [31:0] opa, opa_next;   // right operand b
  logic [31:0] opb, opb_next;   // left operand a
  logic [31:0] acc, acc_next;   // quotient or power accumulator
  logic [31:0] aux, aux_next;   // remainder or squared base
  logic [31:0] ex, ex_next;     // divisor magnitude or exponent
  logic [5:0]  step, step_next;
  logic        neg, neg_next;
  logic [31:0] res, res_next;
  logic        ov, ov_next;
  logic [31:0] ov_val, ov_val_next;
  logic [1:0]  ov_st, ov_st_next;

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic [63:0] prod;
  logic [31:0] mul_x, mul_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pse_pkg::S_IDLE;
      count <= '0;
      err <= pse_pkg::ST_OK;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      err <= err_next;
      ov <= ov_next;
    end
    cmd <= cmd_next; lst <= lst_next; opa <= opa_next; opb <= opb_next;
    acc <= acc_next; aux <= aux_next; ex <= ex_next; step <= step_next;
    neg <= neg_next; res <= res_next; ov_val <= ov_val_next; ov_st <= ov_st_next;
  end

  assign rem_sh = {aux, acc[31]};
  assign rem_sub = rem_sh - {1'b0, ex};
  assign prod = mul_x * mul_y;

  always_comb begin
    state_next = state; count_next = count; err_next = err;
    cmd_next = cmd; lst_next = lst; opa_next = opa; opb_next = opb;
    acc_next = acc; aux_next = aux; ex_next = ex; step_next = step;
    neg_next = neg; res_next = res; ov_next = ov; ov_val_next = ov_val;
    ov_st_next = ov_st;
    rd_addr = pse_pkg::AddrW'(count - 1'b1);
    wr_en = 1'b0; wr_addr = '0; wr_data = operand_value;
    mul_x = opb; mul_y = opa;
    in_stall = 1'b1;
    if (ov && !out_stall) ov_next = 1'b0;
    case (state)
      pse_pkg::S_IDLE: begin
        in_stall = ov;
        if (in_valid && !ov) begin
          cmd_next = command; lst_next = last;
          if (command == pse_pkg::CMD_PUSH) begin
            if (count < pse_pkg::CountW'(pse_pkg::StackDepth)) begin
              wr_en = 1'b1;
              wr_addr = pse_pkg::AddrW'(count);
              count_next = count + 1'b1;
            end else if (err == pse_pkg::ST_OK) err_next = pse_pkg::ST_OVER;
            state_next = last ? pse_pkg::S_FINAL : pse_pkg::S_IDLE;
          end else if (command <= pse_pkg::CMD_POW) begin
            if (count >= pse_pkg::CountW'(2)) state_next = pse_pkg::S_READ;
            else begin
              if (err == pse_pkg::ST_OK) err_next = pse_pkg::ST_UNDER;
              state_next = last ? pse_pkg::S_FINAL : pse_pkg::S_IDLE;
            end
          end else state_next = last ? pse_pkg::S_FINAL : pse_pkg::S_IDLE;
        end
      end
      pse_pkg::S_READ: begin
        // top (b) read issued in IDLE; now issue a
        opa_next = rd_data;
        rd_addr = pse_pkg::AddrW'(count - 2'd2);
        state_next = pse_pkg::S_EXEC;
      end
      pse_pkg::S_EXEC: begin
        opb_next = rd_data;
        state_next = pse_pkg::S_WRITE;
        step_next = '0;
        case (cmd)
          pse_pkg::CMD_ADD: res_next = rd_data + opa;
          pse_pkg::CMD_SUB: res_next = rd_data - opa;
          pse_pkg::CMD_MUL: begin
            mul_x = rd_data; res_next = prod[31:0];
          end
          pse_pkg::CMD_DIV: begin
            if (opa == '0) begin
              res_next = '0;
              if (err == pse_pkg::ST_OK) err_next = pse_pkg::ST_DIVZ;
            end else state_next = pse_pkg::S_ITER;
            acc_next = rd_data[31] ? -rd_data : rd_data;
            aux_next = '0;
            ex_next = opa[31] ? -opa : opa;
            neg_next = rd_data[31] ^ opa[31];
          end
          default: begin
            if (opa[31]) begin
              if (rd_data == 32'd1) res_next = 32'd1;
              else if (rd_data == '1) res_next = opa[0] ? '1 : 32'd1;
              else res_next = '0;
            end else state_next = pse_pkg::S_ITER;
            acc_next = 32'd1; aux_next = rd_data; ex_next = opa;
          end
        endcase
      end
      pse_pkg::S_ITER: begin
        step_next = step + 1'b1;
        if (cmd == pse_pkg::CMD_DIV) begin
          if (!rem_sub[32]) begin
            aux_next = rem_sub[31:0]; acc_next = {acc[30:0], 1'b1};
          end else begin
            aux_next = rem_sh[31:0]; acc_next = {acc[30:0], 1'b0};
          end
          if (step == 6'd31) state_next = pse_pkg::S_WRITE;
          res_next = neg ? -acc_next : acc_next;
        end else begin
          // alternate cycles: multiply acc, then square base
          if (!step[0]) begin
            mul_x = acc; mul_y = aux;
            if (ex[0]) acc_next = prod[31:0];
          end else begin
            mul_x = aux; mul_y = aux;
            aux_next = prod[31:0];
            ex_next = {1'b0, ex[31:1]};
          end
          res_next = acc_next;
          if (step == 6'd61) state_next = pse_pkg::S_WRITE;
        end
      end
      pse_pkg::S_WRITE: begin
        wr_en = 1'b1;
        wr_addr = pse_pkg::AddrW'(count - 2'd2);
        wr_data = res;
        count_next = count - 1'b1;
        state_next = lst ? pse_pkg::S_FINAL : pse_pkg::S_IDLE;
      end
      pse_pkg::S_FINAL: begin
        state_next = pse_pkg::S_OUT;
      end
      pse_pkg::S_OUT: begin
        if (!ov || !out_stall) begin
          ov_next = 1'b1;
          if (count != '0) begin
            ov_val_next = rd_data; ov_st_next = err;
          end else begin
            ov_val_next = '0;
            ov_st_next = (err == pse_pkg::ST_OK) ? pse_pkg::ST_UNDER : err;
          end
          count_next = '0; err_next = pse_pkg::ST_OK;
          state_next = pse_pkg::S_IDLE;
        end
      end
      default: state_next = pse_pkg::S_IDLE;
    endcase
  end

  assign out_valid = ov;
  assign value = ov_val;
  assign status = ov_st;
endmodule
`default_nettype wire

[hw/rtl/pse_checker.sv]
// Port-level checker for the postfix stack evaluator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "postfix_stack_evaluator_macros.svh"
module pse_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        last,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] value,
  input wire logic [1:0]  status
);
  `PSE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(value) && $stable(status), "stalled result changed")
  `PSE_ASSERT_NEXT(a_mid_no_out, clk, rst, in_valid && !in_stall && !last && !out_valid, !out_valid, "result without last request")
  `PSE_ASSERT_NEXT(a_busy_after_op, clk, rst, in_valid && !in_stall && last, in_stall, "took request while finishing expression")
  `PSE_ASSERT_IMP(a_no_accept_full, clk, rst, out_valid && out_stall, in_stall, "request accepted behind held result")
endmodule
bind postfix_stack_evaluator pse_checker u_pse_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .last(last),
  .out_valid(out_valid), .out_stall(out_stall), .value(value), .status(status)
);
`default_nettype wire

[tb/tb_postfix_stack_evaluator.sv]
// Testbench for the postfix stack evaluator: random and directed token streams.
`timescale 1ns / 1ps
`default_nettype none
module tb_postfix_stack_evaluator;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] opnd;
    logic        fin;
  } token_t;

  typedef struct packed {
    logic [31:0] val;
    logic [1:0]  st;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] command = pse_pkg::CMD_PUSH;
  logic signed [31:0] operand_value = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] value;
  logic [1:0] status;

  postfix_stack_evaluator DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .operand_value(operand_value), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .value(value), .status(status)
  );

  always #2 clk = ~clk;

  token_t  pending_tokens[$];
  answer_t expected_answers[$];
  int mismatches = 0;
  int send_idle_pct = 22;
  int recv_idle_pct = 79;

  // predictor state
  logic [31:0] eval_stack[pse_pkg::StackDepth];
  int          eval_depth = 0;
  logic [1:0]  eval_err = pse_pkg::ST_OK;

  function automatic void note_error(logic [1:0] code);
    if (eval_err == pse_pkg::ST_OK) eval_err = code;
  endfunction

  function automatic logic [31:0] wrap_power(logic [31:0] b, logic [31:0] e);
    logic [31:0] acc;
    logic [31:0] sq;
    acc = 32'd1;
    sq = b;
    if (e[31]) begin
      if (b == 32'd1) return 32'd1;
      if (b == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
      return 32'd0;
    end
    for (int i = 0; i < 31; i++) begin
      if (e[i]) acc = acc * sq;
      sq = sq * sq;
    end
    return acc;
  endfunction

  function automatic void evaluate_token(token_t t);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    answer_t ans;
    if (t.cmd == pse_pkg::CMD_PUSH) begin
      if (eval_depth < pse_pkg::StackDepth) begin
        eval_stack[eval_depth] = t.opnd;
        eval_depth++;
      end else note_error(pse_pkg::ST_OVER);
    end else if (t.cmd <= pse_pkg::CMD_POW) begin
      if (eval_depth >= 2) begin
        b = eval_stack[eval_depth-1];
        a = eval_stack[eval_depth-2];
        case (t.cmd)
          pse_pkg::CMD_ADD: r = a + b;
          pse_pkg::CMD_SUB: r = a - b;
          pse_pkg::CMD_MUL: r = a * b;
          pse_pkg::CMD_DIV: begin
            if (b == 32'd0) begin
              note_error(pse_pkg::ST_DIVZ);
              r = 32'd0;
            end else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
              r = a;
            end else begin
              r = $signed(a) / $signed(b);
            end
          end
          default: r = wrap_power(a, b);
        endcase
        eval_depth--;
        eval_stack[eval_depth-1] = r;
      end else note_error(pse_pkg::ST_UNDER);
    end
    if (t.fin) begin
      if (eval_depth > 0) ans.val = eval_stack[eval_depth-1];
      else begin
        ans.val = 32'd0;
        note_error(pse_pkg::ST_UNDER);
      end
      ans.st = eval_err;
      expected_answers.push_back(ans);
      eval_depth = 0;
      eval_err = pse_pkg::ST_OK;
    end
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      4: return 32'd1;
      5: return $urandom_range(0, 9) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_token(logic [2:0] c, logic [31:0] v, logic f);
    token_t t;
    t.cmd = c;
    t.opnd = v;
    t.fin = f;
    pending_tokens.push_back(t);
  endtask

  // well-formed expression with random content, occasionally broken
  task automatic add_expression();
    int n_ops;
    int depth;
    logic [2:0] op;
    n_ops = $urandom_range(0, 5);
    add_token(pse_pkg::CMD_PUSH, rand_operand(), n_ops == 0);
    depth = 1;
    for (int i = 0; i < n_ops; i++) begin
      add_token(pse_pkg::CMD_PUSH, rand_operand(), 1'b0);
      depth++;
      if ($urandom_range(0, 3) == 0) begin
        add_token(pse_pkg::CMD_PUSH, rand_operand(), 1'b0);
        depth++;
      end
      while (depth > 1) begin
        op = 3'($urandom_range(1, 5));
        if ($urandom_range(0, 40) == 0) op = 3'($urandom_range(6, 7));
        else if ($urandom_range(0, 30) == 0) op = 3'($urandom_range(0, 7));
        depth = (op >= pse_pkg::CMD_ADD && op <= pse_pkg::CMD_POW) ? depth - 1 : depth;
        add_token(op, $urandom, (i == n_ops - 1) && depth == 1);
        if (op == pse_pkg::CMD_PUSH || op > pse_pkg::CMD_POW) break;
      end
    end
    if (depth != 1 || pending_tokens[$].fin == 1'b0)
      add_token(3'($urandom_range(0, 7)), $urandom, 1'b1);
  endtask

  task automatic wait_drained();
    while (pending_tokens.size() > 0 || expected_answers.size() > 0) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      if (pending_tokens.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        token_t t;
        t = pending_tokens.pop_front();
        evaluate_token(t);
        command <= t.cmd;
        operand_value <= t.opnd;
        last <= t.fin;
      end else in_valid <= 1'b0;
    end else if (!in_valid) begin
      if (pending_tokens.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        token_t t;
        t = pending_tokens.pop_front();
        evaluate_token(t);
        command <= t.cmd;
        operand_value <= t.opnd;
        last <= t.fin;
        in_valid <= 1'b1;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%0d status=%0d", value, status);
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (e.val !== value || e.st !== status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                     $signed(e.val), e.st, value, status);
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, every operator, special cases
    add_token(pse_pkg::CMD_PUSH, 32'h8000_0000, 1'b0);
    add_token(pse_pkg::CMD_PUSH, 32'hFFFF_FFFF, 1'b0);
    add_token(pse_pkg::CMD_DIV, 32'd0, 1'b1);
    add_token(pse_pkg::CMD_PUSH, 32'd7, 1'b0); add_token(pse_pkg::CMD_PUSH, 32'd0, 1'b0);
    add_token(pse_pkg::CMD_DIV, 32'd0, 1'b1);
    add_token(pse_pkg::CMD_PUSH, 32'd3, 1'b0);
    add_token(pse_pkg::CMD_PUSH, 32'hFFFF_FFFE, 1'b0);
    add_token(pse_pkg::CMD_POW, 32'd0, 1'b1);
    add_token(pse_pkg::CMD_PUSH, 32'hFFFF_FFFF, 1'b0);
    add_token(pse_pkg::CMD_PUSH, 32'hFFFF_FFFD, 1'b0);
    add_token(pse_pkg::CMD_POW, 32'd0, 1'b1);
    add_token(pse_pkg::CMD_PUSH, 32'd0, 1'b0); add_token(pse_pkg::CMD_PUSH, 32'd0, 1'b0);
    add_token(pse_pkg::CMD_POW, 32'd0, 1'b1);
    add_token(pse_pkg::CMD_ADD, 32'd0, 1'b1);
    add_token(3'd6, 32'h7FFF_FFFF, 1'b0); add_token(3'd7, 32'd0, 1'b1);
    add_token(pse_pkg::CMD_PUSH, 32'h7FFF_FFFF, 1'b0); add_token(pse_pkg::CMD_PUSH, 32'd1, 1'b0);
    add_token(pse_pkg::CMD_ADD, 32'd0, 1'b0); add_token(pse_pkg::CMD_PUSH, 32'd2, 1'b0);
    add_token(pse_pkg::CMD_SUB, 32'd0, 1'b0);
    add_token(pse_pkg::CMD_PUSH, 32'h10001, 1'b0); add_token(pse_pkg::CMD_MUL, 32'd0, 1'b1);
    // overflow, then error stays sticky
    for (int i = 0; i < pse_pkg::StackDepth + 2; i++)
      add_token(pse_pkg::CMD_PUSH, $urandom, 1'b0);
    add_token(pse_pkg::CMD_PUSH, 32'd0, 1'b0); add_token(pse_pkg::CMD_DIV, 32'd0, 1'b1);
    wait_drained();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 79 : 0;
      recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 22 : 0;
      while (pending_tokens.size() < 340) add_expression();
      wait_drained();
    end
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
+incdir+hw/rtl
hw/rtl/pse_pkg.sv
hw/rtl/postfix_stack_evaluator.sv
hw/rtl/pse_checker.sv
tb/tb_postfix_stack_evaluator.sv
